// File: src/upd_pkg.sv
// Shared types, constants and helper function of the URL percent decoder.
package upd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned NibbleW  = 4;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ByteW-1:0]   CharNul     = 8'h00;
  localparam logic [ByteW-1:0]   CharPercent = 8'h25;
  localparam logic [ByteW-1:0]   CharPlus    = 8'h2B;
  localparam logic [ByteW-1:0]   CharSpace   = 8'h20;
  localparam logic [NibbleW-1:0] NibbleMask  = 4'hF;

  localparam logic [ByteW-1:0] StopFirstRst  = 8'd61;
  localparam logic [ByteW-1:0] StopSecondRst = 8'd38;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STOP_FIRST  = 2'd0,
    CFG_FIRST_EN    = 2'd1,
    CFG_STOP_SECOND = 2'd2,
    CFG_SECOND_EN   = 2'd3
  } cfg_idx_e;

  typedef enum logic [KindW-1:0] {
    KIND_DATA  = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'b001,
    MODE_HIGH  = 3'b010,
    MODE_LOW   = 3'b100
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0] stop_first;
    logic             first_en;
    logic [ByteW-1:0] stop_second;
    logic             second_en;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    kind_e            kind;
    logic [ByteW-1:0] value;
    logic             done;
  } result_t;

  // Return {not_hex, digit}; digit is zero when the byte is not a hex digit.
  function automatic logic [NibbleW:0] hex_value(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] diff;
    logic [NibbleW:0] res;
    diff = '0;
    res  = {1'b1, {NibbleW{1'b0}}};
    if (b >= 8'h30 && b <= 8'h39) begin
      diff = b - 8'h30;
      res  = {1'b0, diff[NibbleW-1:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      diff = b - 8'h57;
      res  = {1'b0, diff[NibbleW-1:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      diff = b - 8'h37;
      res  = {1'b0, diff[NibbleW-1:0]};
    end
    return res;
  endfunction

endpackage

// File: src/upd_stream_if.sv
// Valid/ready stream interfaces for the decoder input and result channels.
interface upd_in_if;
  logic                    valid;
  logic                    ready;
  logic [upd_pkg::ByteW-1:0] in_byte;
  logic                    end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface upd_out_if;
  logic                      valid;
  logic                      ready;
  logic [upd_pkg::KindW-1:0] result_kind;
  logic [upd_pkg::ByteW-1:0] result_value;
  logic                      stream_done;

  modport source (output valid, output result_kind, output result_value,
                  output stream_done, input ready);
  modport sink   (input valid, input result_kind, input result_value,
                  input stream_done, output ready);
endinterface

// File: src/upd_cfg_regs.sv
// Configuration registers for the stop characters and their enables.
module upd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [upd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [upd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output upd_pkg::cfg_t                cfg_o
);

  upd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (upd_pkg::cfg_idx_e'(cfg_index_i))
        upd_pkg::CFG_STOP_FIRST:  cfg_d.stop_first  = cfg_wdata_i;
        upd_pkg::CFG_FIRST_EN:    cfg_d.first_en    = cfg_wdata_i[0];
        upd_pkg::CFG_STOP_SECOND: cfg_d.stop_second = cfg_wdata_i;
        upd_pkg::CFG_SECOND_EN:   cfg_d.second_en   = cfg_wdata_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_first  <= upd_pkg::StopFirstRst;
      cfg_q.first_en    <= 1'b0;
      cfg_q.stop_second <= upd_pkg::StopSecondRst;
      cfg_q.second_en   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/upd_step.sv
// Decode step: escape mode, held high nibble and the per-byte result logic.
module upd_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [upd_pkg::ByteW-1:0]  in_byte_i,
  input  logic                       end_of_input_i,
  input  upd_pkg::cfg_t              cfg_i,
  output upd_pkg::result_t           res_o
);

  upd_pkg::mode_e                mode_q, mode_d;
  logic [upd_pkg::NibbleW-1:0]   nibble_q, nibble_d;
  logic [upd_pkg::NibbleW:0]     hex;
  logic                          not_hex;
  logic [upd_pkg::NibbleW-1:0]   digit;
  logic                          stop_hit;

  assign hex     = upd_pkg::hex_value(in_byte_i);
  assign not_hex = hex[upd_pkg::NibbleW];
  assign digit   = hex[upd_pkg::NibbleW-1:0] & upd_pkg::NibbleMask;

  assign stop_hit = (in_byte_i == upd_pkg::CharNul)
                 || (cfg_i.first_en  && in_byte_i == cfg_i.stop_first)
                 || (cfg_i.second_en && in_byte_i == cfg_i.stop_second);

  always_comb begin
    mode_d       = mode_q;
    nibble_d     = nibble_q;
    res_o.valid  = 1'b0;
    res_o.kind   = upd_pkg::KIND_DATA;
    res_o.value  = in_byte_i;
    res_o.done   = end_of_input_i;
    case (mode_q)
      upd_pkg::MODE_HIGH: begin
        if (not_hex || end_of_input_i) begin
          mode_d      = upd_pkg::MODE_PLAIN;
          res_o.valid = 1'b1;
          res_o.kind  = upd_pkg::KIND_ERROR;
          res_o.value = '0;
          res_o.done  = 1'b0;
        end else begin
          nibble_d = digit;
          mode_d   = upd_pkg::MODE_LOW;
        end
      end
      upd_pkg::MODE_LOW: begin
        mode_d      = upd_pkg::MODE_PLAIN;
        res_o.valid = 1'b1;
        if (not_hex) begin
          res_o.kind  = upd_pkg::KIND_ERROR;
          res_o.value = '0;
          res_o.done  = 1'b0;
        end else begin
          res_o.value = {nibble_q, digit};
        end
      end
      default: begin
        mode_d = upd_pkg::MODE_PLAIN;
        if (in_byte_i == upd_pkg::CharPercent) begin
          if (end_of_input_i) begin
            res_o.valid = 1'b1;
            res_o.kind  = upd_pkg::KIND_ERROR;
            res_o.value = '0;
            res_o.done  = 1'b0;
          end else begin
            mode_d = upd_pkg::MODE_HIGH;
          end
        end else if (stop_hit) begin
          res_o.valid = 1'b1;
          res_o.kind  = upd_pkg::KIND_STOP;
        end else if (in_byte_i == upd_pkg::CharPlus) begin
          res_o.valid = 1'b1;
          res_o.value = upd_pkg::CharSpace;
        end else begin
          res_o.valid = 1'b1;
        end
      end
    endcase
  end

  // Advance the mode only when the held byte is taken from the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= upd_pkg::MODE_PLAIN;
      nibble_q <= '0;
    end else if (advance_i) begin
      mode_q   <= mode_d;
      nibble_q <= nibble_d;
    end
  end

endmodule

// File: src/url_percent_decoder_top.sv
// A byte is decoded from the input register and its result goes to the result
// register. Throughput: one byte per cycle unless results stall; the input and
// result registers let a byte in while a finished result waits to be taken.
// Bytes that open or continue an escape move through without a result.
// Reset (rst_ni low, asynchronous) clears both stages, returns to plain mode
// and loads the stop characters '=' and '&' with both enables off.
module url_percent_decoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  upd_in_if.sink                       in_s,
  upd_out_if.source                    out_m,
  input  logic                         cfg_we_i,
  input  logic [upd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [upd_pkg::CfgDataW-1:0] cfg_wdata_i
);

  upd_pkg::cfg_t             cfg;
  upd_pkg::result_t          res;

  logic                      in_valid_q, in_valid_d;
  logic [upd_pkg::ByteW-1:0] in_byte_q;
  logic                      in_last_q;
  logic                      out_valid_q, out_valid_d;
  upd_pkg::kind_e            out_kind_q;
  logic [upd_pkg::ByteW-1:0] out_value_q;
  logic                      out_done_q;
  logic                      advance;
  logic                      in_ready;

  upd_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  upd_step u_step (
    .clk_i,
    .rst_ni,
    .advance_i      (advance),
    .in_byte_i      (in_byte_q),
    .end_of_input_i (in_last_q),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  assign advance  = in_valid_q && (!out_valid_q || out_m.ready);
  assign in_ready = !in_valid_q || advance;
  assign in_s.ready = in_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready) in_valid_d = in_s.valid;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.valid;
    end else if (out_m.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payloads until the next transaction loads them.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_s.valid) begin
      in_byte_q <= in_s.in_byte;
      in_last_q <= in_s.end_of_input;
    end
    if (advance && res.valid) begin
      out_kind_q  <= res.kind;
      out_value_q <= res.value;
      out_done_q  <= res.done;
    end
  end

  assign out_m.valid        = out_valid_q;
  assign out_m.result_kind  = out_kind_q;
  assign out_m.result_value = out_value_q;
  assign out_m.stream_done  = out_done_q;

endmodule

// File: src/upd_checker.sv
// Port-level checker for the URL percent decoder, bound to the top level.
module upd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [upd_pkg::KindW-1:0] out_kind_i,
  input logic [upd_pkg::ByteW-1:0] out_value_i,
  input logic                      out_done_i
);

  // A stalled result holds its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
      && $stable(out_value_i) && $stable(out_done_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_kind_i == upd_pkg::KIND_DATA
      || out_kind_i == upd_pkg::KIND_STOP || out_kind_i == upd_pkg::KIND_ERROR))
    else $error("illegal result kind");

  // An error never carries a value and never ends the stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == upd_pkg::KIND_ERROR
      |-> out_value_i == '0 && !out_done_i)
    else $error("error result with value or done");

  // No result is valid in the cycle after reset is sampled asserted.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid out of reset");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_m.valid),
  .out_ready_i (out_m.ready),
  .out_kind_i  (out_m.result_kind),
  .out_value_i (out_m.result_value),
  .out_done_i  (out_m.stream_done)
);

// File: verif/url_percent_decoder_top_tb.sv
// Self-checking testbench for the URL percent decoder: directed and random byte streams.
`timescale 1ns / 100ps

module url_percent_decoder_top_tb;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseBytes   = 330;

  typedef struct packed {
    logic [upd_pkg::ByteW-1:0] data;
    logic                      last;
  } raw_byte_t;

  typedef struct packed {
    upd_pkg::kind_e            kind;
    logic [upd_pkg::ByteW-1:0] value;
    logic                      done;
  } decoded_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [upd_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [upd_pkg::CfgDataW-1:0] cfg_wdata_i;

  upd_in_if  in_if ();
  upd_out_if out_if ();

  url_percent_decoder_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_if),
    .out_m       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  raw_byte_t pending_bytes[$];
  decoded_t  expected_results[$];

  // Decoder state and register copies
  upd_pkg::mode_e              mode_q        = upd_pkg::MODE_PLAIN;
  logic [upd_pkg::NibbleW-1:0] nibble_q      = '0;
  logic [upd_pkg::ByteW-1:0]   stop_first_q  = upd_pkg::StopFirstRst;
  logic [upd_pkg::ByteW-1:0]   stop_second_q = upd_pkg::StopSecondRst;
  logic                        first_en_q    = 1'b0;
  logic                        second_en_q   = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned bytes_offered  = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatches     = 0;
  int unsigned cycles         = 0;

  always #1 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Return {is_hex, digit value}.
  function automatic logic [upd_pkg::NibbleW:0] hex_digit(input logic [upd_pkg::ByteW-1:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return '0;
  endfunction

  function automatic void decode_byte(input raw_byte_t item);
    logic [upd_pkg::NibbleW:0] digit;
    decoded_t                  res;
    logic                      has_res;
    digit   = hex_digit(item.data);
    has_res = 1'b1;
    res     = '{kind: upd_pkg::KIND_ERROR, value: '0, done: 1'b0};
    case (mode_q)
      upd_pkg::MODE_HIGH: begin
        mode_q = upd_pkg::MODE_PLAIN;
        // a good high digit on the last byte closes the escape with an error
        if (digit[upd_pkg::NibbleW] && !item.last) begin
          nibble_q = digit[upd_pkg::NibbleW-1:0];
          mode_q   = upd_pkg::MODE_LOW;
          has_res  = 1'b0;
        end
      end
      upd_pkg::MODE_LOW: begin
        mode_q = upd_pkg::MODE_PLAIN;
        if (digit[upd_pkg::NibbleW]) begin
          res = '{kind: upd_pkg::KIND_DATA,
                  value: {nibble_q, digit[upd_pkg::NibbleW-1:0]},
                  done: item.last};
        end
      end
      default: begin
        mode_q = upd_pkg::MODE_PLAIN;
        if (item.data == upd_pkg::CharPercent) begin
          if (!item.last) begin
            mode_q  = upd_pkg::MODE_HIGH;
            has_res = 1'b0;
          end
        end else if (item.data == upd_pkg::CharNul ||
                     (first_en_q && item.data == stop_first_q) ||
                     (second_en_q && item.data == stop_second_q)) begin
          res = '{kind: upd_pkg::KIND_STOP, value: item.data, done: item.last};
        end else if (item.data == upd_pkg::CharPlus) begin
          res = '{kind: upd_pkg::KIND_DATA, value: upd_pkg::CharSpace, done: item.last};
        end else begin
          res = '{kind: upd_pkg::KIND_DATA, value: item.data, done: item.last};
        end
      end
    endcase
    if (has_res) expected_results.push_back(res);
  endfunction

  function automatic void queue_byte(input logic [upd_pkg::ByteW-1:0] b, input logic last);
    pending_bytes.push_back('{data: b, last: last});
  endfunction

  function automatic void queue_text(input string s, input logic last_on_end);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i], last_on_end && (i == s.len() - 1));
    end
  endfunction

  function automatic logic rare_last();
    return $urandom_range(11, 0) == 0;
  endfunction

  function automatic logic [upd_pkg::ByteW-1:0] hex_char(
      input logic [upd_pkg::NibbleW-1:0] v);
    if (v < 10) return "0" + v;
    return ($urandom_range(1, 0) ? "A" : "a") + v - 8'd10;
  endfunction

  function automatic void queue_random_bytes(input int unsigned count);
    int unsigned               added;
    int unsigned               pick;
    logic [upd_pkg::ByteW-1:0] b;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
        queue_byte(8'($urandom_range(255, 0)), rare_last());
        added += 1;
      end else if (pick < 50) begin
        case ($urandom_range(3, 0))
          0:       b = stop_first_q;
          1:       b = stop_second_q;
          2:       b = upd_pkg::CharPlus;
          default: b = upd_pkg::CharNul;
        endcase
        queue_byte(b, rare_last());
        added += 1;
      end else if (pick < 85) begin
        queue_byte(upd_pkg::CharPercent, $urandom_range(39, 0) == 0);
        queue_byte(hex_char(4'($urandom_range(15, 0))), $urandom_range(39, 0) == 0);
        queue_byte(hex_char(4'($urandom_range(15, 0))), rare_last());
        added += 3;
      end else begin
        // broken escape: arbitrary bytes where the digits belong
        queue_byte(upd_pkg::CharPercent, $urandom_range(19, 0) == 0);
        queue_byte(8'($urandom_range(255, 0)), rare_last());
        queue_byte(8'($urandom_range(255, 0)), rare_last());
        added += 3;
      end
    end
  endfunction

  task automatic write_reg(input upd_pkg::cfg_idx_e idx,
                           input logic [upd_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      upd_pkg::CFG_STOP_FIRST:  stop_first_q  = val;
      upd_pkg::CFG_FIRST_EN:    first_en_q    = val[0];
      upd_pkg::CFG_STOP_SECOND: stop_second_q = val;
      upd_pkg::CFG_SECOND_EN:   second_en_q   = val[0];
      default: ;
    endcase
  endtask

  task automatic write_stops(input logic [upd_pkg::ByteW-1:0] first, input logic first_en,
                             input logic [upd_pkg::ByteW-1:0] second, input logic second_en);
    write_reg(upd_pkg::CFG_STOP_FIRST, first);
    write_reg(upd_pkg::CFG_FIRST_EN, {7'd0, first_en});
    write_reg(upd_pkg::CFG_STOP_SECOND, second);
    write_reg(upd_pkg::CFG_SECOND_EN, {7'd0, second_en});
  endtask

  // Hold until every byte is taken and every result is back, then let the pipe drain.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Check results first, then predict the byte taken at this edge.
  always @(posedge clk_i) begin : accept_and_check
    decoded_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("result with none expected: kind %0d value %02h done %0b",
                                out_if.result_kind, out_if.result_value, out_if.stream_done));
      end else begin
        want = expected_results.pop_front();
        if (out_if.result_kind !== want.kind)
          flag_mismatch($sformatf("result_kind %0d, expected %0d", out_if.result_kind, want.kind));
        if (out_if.result_value !== want.value)
          flag_mismatch($sformatf("result_value %02h, expected %02h",
                                  out_if.result_value, want.value));
        if (out_if.stream_done !== want.done)
          flag_mismatch($sformatf("stream_done %0b, expected %0b",
                                  out_if.stream_done, want.done));
      end
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      decode_byte(pending_bytes.pop_front());
      bytes_accepted <= bytes_accepted + 1;
    end
  end

  // Present the head of the queue; hold it until the transaction completes.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (bytes_offered == bytes_accepted) begin
      if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_if.valid        <= 1'b1;
        in_if.in_byte      <= pending_bytes[0].data;
        in_if.end_of_input <= pending_bytes[0].last;
        bytes_offered      <= bytes_offered + 1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= rst_ni && ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = upd_pkg::CFG_STOP_FIRST;
    cfg_wdata_i        = '0;
    in_if.valid        = 1'b0;
    in_if.in_byte      = '0;
    in_if.end_of_input = 1'b0;
    out_if.ready       = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers, stops disabled
    queue_text("a+", 1'b0);
    queue_byte(upd_pkg::CharNul, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_text("%4A%fF%Z=%4G", 1'b0);
    queue_text("%", 1'b1);
    queue_text("%4", 1'b1);
    queue_text("%00", 1'b1);
    queue_byte(upd_pkg::CharNul, 1'b1);
    wait_idle();

    // Percent sign as an enabled stop still opens an escape
    write_stops(upd_pkg::CharPercent, 1'b1, "&", 1'b1);
    queue_text("%3d&", 1'b0);
    queue_text("&", 1'b1);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_stops(8'h00, 1'b1, 8'hFF, 1'b1);
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          write_stops("=", 1'b1, "&", 1'b1);
          send_idle_pct = 64;
          stall_pct     = 0;
        end
        2: begin
          write_stops(8'($urandom_range(255, 0)), 1'b0, upd_pkg::CharPlus, 1'b1);
          send_idle_pct = 0;
          stall_pct     = 64;
        end
        default: begin
          write_stops(8'hFF, 1'b1, 8'h00, 1'b0);
          send_idle_pct = 38;
          stall_pct     = 38;
        end
      endcase
      queue_random_bytes(PhaseBytes);
    end

    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
